/* rtl/core/bpbs_pkg.sv */
// Shared types and constants for the binary to packed BCD converter.
// No dependencies; imported by the converter core and its BCD stage.
package bpbs_pkg;

   typedef enum logic [1:0] {
      OP_PER_BYTE = 2'd0,
      OP_WORD     = 2'd1,
      OP_METER    = 2'd2
   } op_type;

   localparam int VALUE_W   = 64;
   localparam int BCD_W     = 64;
   localparam int DIGITS    = BCD_W / 4;
   localparam int MAG_W     = 54;
   localparam int STEP_BITS = 6;
   localparam int DAB_STAGES = (MAG_W + STEP_BITS - 1) / STEP_BITS;

   localparam int ST_IN   = 0;
   localparam int ST_DEC  = 1;
   localparam int ST_RNG  = 2;
   localparam int NSTG    = ST_RNG + 1 + DAB_STAGES;

   localparam logic [31:0] LIM_BYTE   = 32'd99;
   localparam logic [31:0] LIM_WORD   = 32'd9999;
   localparam logic [31:0] LIM_DWORD  = 32'd99999999;
   localparam logic [63:0] SPLIT_BASE = 64'd100000000;
   localparam logic [63:0] MAG_LIMIT  = 64'(SPLIT_BASE * SPLIT_BASE);
   localparam logic [7:0]  SIGN_MARK  = 8'h80;

   typedef struct packed {
      logic [1:0]         op;
      logic [3:0]         n;
      logic               neg;
      logic               ok;
      logic [VALUE_W-1:0] mag;
      logic [BCD_W-1:0]   bcd;
      logic [BCD_W-1:0]   pb;
   } beat_type;

endpackage

/* rtl/core/bpbs_dabble.sv */
// Shift-and-add-3 block: folds STEP_BITS binary bits, MSB first, into a BCD accumulator.
// Depends on bpbs_pkg.
module bpbs_dabble (
   input  logic [bpbs_pkg::BCD_W-1:0]     bcd_in,
   input  logic [bpbs_pkg::STEP_BITS-1:0] bits_in,
   output logic [bpbs_pkg::BCD_W-1:0]     bcd_out
);
   import bpbs_pkg::*;

   always_comb begin
      logic [BCD_W-1:0] acc;
      int s;
      int d;
      acc = bcd_in;
      for (s = STEP_BITS - 1; s >= 0; s--) begin
         for (d = 0; d < DIGITS; d++) begin
            if (acc[4*d +: 4] >= 4'd5) begin
               acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
            end
         end
         acc = {acc[BCD_W-2:0], bits_in[s]};
      end
      bcd_out = acc;
   end

endmodule

/* rtl/core/binary_to_packed_bcd_signed.sv */
// Binary to packed BCD converter, per-byte, word and signed meter modes.
// Pipeline: input register, decode, range check, nine 6-bit shift-and-add-3 stages,
// output register. Throughput: one beat per cycle while rsp_tready is high.
// Each stage holds one beat and stalls only when full.
// Reset: synchronous, active high; clears all stage valids, no clearing pass.
// Depends on bpbs_pkg and bpbs_dabble.
module binary_to_packed_bcd_signed (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // [3:0] byte_count, [67:4] value_in, [71:68] zero
   input  logic [1:0]  req_tuser,  // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // [63:0] bcd_out
   output logic [0:0]  rsp_tuser   // [0] ok
);
   import bpbs_pkg::*;

   beat_type              stage_ff [NSTG];
   beat_type              stage_in [NSTG];
   logic [NSTG-1:0]       valid_ff;
   logic [NSTG:0]         rdy;
   logic [BCD_W-1:0]      dab_out [DAB_STAGES];
   logic                  out_valid_ff;
   logic [BCD_W-1:0]      out_data_ff;
   logic [BCD_W-1:0]      out_data_in;
   logic                  out_ok_ff;

   function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
      logic [63:0] m;
      int i;
      m = '0;
      for (i = 0; i < 8; i++) begin
         if (cnt > 4'(i)) begin
            m[8*i +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   always_comb begin
      int k;
      rdy[NSTG] = !out_valid_ff || rsp_tready;
      for (k = NSTG - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign req_tready = rdy[ST_IN];

   // input register
   always_comb begin
      stage_in[ST_IN]     = '0;
      stage_in[ST_IN].op  = req_tuser;
      stage_in[ST_IN].n   = req_tdata[3:0];
      stage_in[ST_IN].mag = req_tdata[67:4];
   end

   // decode, per-byte conversion, word masking and limit check, meter sign and magnitude
   always_comb begin
      beat_type         src;
      logic [7:0]       b;
      logic [15:0]      prod;
      logic [3:0]       tens;
      logic [7:0]       ones;
      logic             bad_byte;
      logic [31:0]      w;
      logic [31:0]      lim;
      logic             len_ok;
      logic [63:0]      sval;
      int i;
      src      = stage_ff[ST_IN];
      bad_byte = 1'b0;
      w        = '0;
      lim      = '0;
      len_ok   = 1'b0;
      sval     = '0;
      stage_in[ST_DEC]     = '0;
      stage_in[ST_DEC].op  = src.op;
      stage_in[ST_DEC].n   = src.n;
      for (i = 0; i < 8; i++) begin
         b    = src.mag[8*i +: 8];
         prod = 16'(b) * 16'd205;
         tens = prod[14:11];
         ones = b - ({1'b0, tens, 3'b000} + {3'b000, tens, 1'b0});
         if (src.n > 4'(i)) begin
            stage_in[ST_DEC].pb[8*i +: 8] = {tens, ones[3:0]};
            if (b > 8'd99) begin
               bad_byte = 1'b1;
            end
         end
      end
      case (src.op)
         OP_PER_BYTE: begin
            stage_in[ST_DEC].ok = (src.n <= 4'd8) && !bad_byte;
         end
         OP_WORD: begin
            case (src.n)
               4'd1: begin
                  lim    = LIM_BYTE;
                  len_ok = 1'b1;
               end
               4'd2: begin
                  lim    = LIM_WORD;
                  len_ok = 1'b1;
               end
               4'd4: begin
                  lim    = LIM_DWORD;
                  len_ok = 1'b1;
               end
               default: begin
                  lim    = '0;
                  len_ok = 1'b0;
               end
            endcase
            w = 32'(src.mag & byte_mask(src.n));
            stage_in[ST_DEC].ok  = len_ok && (w <= lim);
            stage_in[ST_DEC].mag = {32'd0, w};
         end
         OP_METER: begin
            // short form sign-extends the low word; the most negative values
            // fall out in the range check
            if (src.n <= 4'd4) begin
               sval = {{32{src.mag[31]}}, src.mag[31:0]};
            end else begin
               sval = src.mag;
            end
            stage_in[ST_DEC].neg = sval[63];
            stage_in[ST_DEC].mag = sval[63] ? (64'd0 - sval) : sval;
            stage_in[ST_DEC].ok  = (src.n != 4'd0) && (src.n <= 4'd8);
         end
         default: begin
            stage_in[ST_DEC].ok = 1'b0;
         end
      endcase
   end

   // meter magnitude range check, clear BCD accumulator
   always_comb begin
      stage_in[ST_RNG]     = stage_ff[ST_DEC];
      stage_in[ST_RNG].bcd = '0;
      if (stage_ff[ST_DEC].op == OP_METER) begin
         if (stage_ff[ST_DEC].n <= 4'd4) begin
            if (stage_ff[ST_DEC].mag > {32'd0, LIM_DWORD}) begin
               stage_in[ST_RNG].ok = 1'b0;
            end
         end else begin
            if (stage_ff[ST_DEC].mag >= MAG_LIMIT) begin
               stage_in[ST_RNG].ok = 1'b0;
            end
         end
      end
   end

   for (genvar j = 0; j < DAB_STAGES; j++) begin : g_dab
      bpbs_dabble u_dabble (
         .bcd_in  (stage_ff[ST_RNG+j].bcd),
         .bits_in (stage_ff[ST_RNG+j].mag[MAG_W-1 -: STEP_BITS]),
         .bcd_out (dab_out[j])
      );

      always_comb begin
         stage_in[ST_RNG+1+j]     = stage_ff[ST_RNG+j];
         stage_in[ST_RNG+1+j].bcd = dab_out[j];
         stage_in[ST_RNG+1+j].mag = {stage_ff[ST_RNG+j].mag[VALUE_W-1-STEP_BITS:0],
                                     {STEP_BITS{1'b0}}};
      end
   end

   // result assembly
   always_comb begin
      beat_type    fin;
      logic [6:0]  sign_pos;
      fin      = stage_ff[NSTG-1];
      sign_pos = {fin.n - 4'd1, 3'b000};
      if (fin.op == OP_PER_BYTE) begin
         out_data_in = fin.pb;
      end else begin
         out_data_in = fin.bcd & byte_mask(fin.n);
      end
      if (fin.neg) begin
         out_data_in = out_data_in | (64'(SIGN_MARK) << sign_pos);
      end
      if (!fin.ok) begin
         out_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= (k == ST_IN) ? req_tvalid : valid_ff[(k == 0) ? 0 : k-1];
            end
         end
         if (rdy[NSTG]) begin
            out_valid_ff <= valid_ff[NSTG-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (rdy[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
      if (rdy[NSTG]) begin
         out_data_ff <= out_data_in;
         out_ok_ff   <= stage_ff[NSTG-1].ok;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_ok_ff;

endmodule

/* rtl/core/bpbs_checker.sv */
// Port-level assertions for the binary to packed BCD converter.
// Bound to binary_to_packed_bcd_signed; no package dependency.
module bpbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   logic digits_ok;

   // low nibble of every byte is a decimal digit; high nibble may carry the sign mark
   always_comb begin
      digits_ok = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (rsp_tdata[8*i +: 4] > 4'd9) begin
            digits_ok = 1'b0;
         end
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("rejected beat carries nonzero data");

   a_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> digits_ok)
      else $error("result digit above nine");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output register empty");

endmodule

bind binary_to_packed_bcd_signed bpbs_checker u_bpbs_checker (.*);
